>>> design/spms_pkg.sv
// Shared types and codes for the shared-pool multi-stack core.
package spms_pkg;

	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic               action;
		logic [1:0]         stack_sel;
		logic signed [31:0] push_data;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] pop_data;
		logic [1:0]         status;
	} out_word_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

endpackage

>>> design/shared_pool_multi_stack_core.sv
// Top level: several LIFO stacks sharing one linked entry pool with a free list.
//
// Input channel in_valid/in_ready/in_word carries one operation word: a push of
// push_data onto stack stack_sel, or a pop from it. Output channel
// out_valid/out_ready/out_word returns one word per operation: the popped data
// (all ones on an empty pop, zero for a push) and a status code.
// An operation has two steps: the accept cycle issues the read of the link
// and data memories, the next cycle writes the link memory (and the data
// memory on a push), updates the stack tops and free head, and loads the
// output register; no new word is accepted until this write step is done.
// The output register holds a result until it is taken; a new word is accepted
// only when that register is empty or drains in the same cycle, so a stalled
// receiver holds the input side after at most one buffered result.
// Reset leaves all stacks empty and every entry on the free list in order. No
// clearing pass is needed: a high-water count marks entries never allocated,
// whose link reads as the next index, so the block is ready right after reset.
// A stack_sel of STACKS or more names a stack that is always empty and full.
module shared_pool_multi_stack_core #(
	parameter int ENTRIES    = 128,
	parameter int STACKS     = 3,
	parameter int DATA_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  spms_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output spms_pkg::out_word_t out_word
);
	import spms_pkg::*;

	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int LINK_W = $clog2(ENTRIES + 1);
	localparam int SEL_W  = (STACKS > 1) ? $clog2(STACKS) : 1;
	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(ENTRIES);

	// pool memories
	logic [DATA_WIDTH-1:0] data_mem [ENTRIES];
	logic [LINK_W-1:0]     link_mem [ENTRIES];

	logic [LINK_W-1:0] stack_top_q [STACKS];
	logic [LINK_W-1:0] free_head_q;
	logic [LINK_W-1:0] hwm_q;
	state_t            state_q, state_d;

	logic                  action_s1;
	logic                  sel_ok_s1;
	logic [SEL_W-1:0]      idx_s1;
	logic [DATA_WIDTH-1:0] data_s1;
	logic [LINK_W-1:0]     top_s1;
	logic [DATA_WIDTH-1:0] data_rd_s1;
	logic [LINK_W-1:0]     link_rd_s1;

	logic                  out_valid_q;
	out_word_t             out_word_q;

	logic                  accept;
	logic [SEL_W+1:0]      sel_ext;
	logic [SEL_W-1:0]      idx_in;
	logic                  sel_ok_in;
	logic [LINK_W-1:0]     top_in;
	logic [IDX_W-1:0]      rd_addr;
	logic [DATA_WIDTH+31:0] data_in_ext;

	logic                  push_ok, pop_ok;
	logic                  link_we, data_we;
	logic [IDX_W-1:0]      wr_addr;
	logic [LINK_W-1:0]     wr_link;
	logic [LINK_W-1:0]     head_link;
	logic                  load_out;
	out_word_t             out_d;
	logic [DATA_WIDTH+31:0] pop_ext;
	logic [DATA_WIDTH+31:0] ones_ext;

	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	assign sel_ext     = {{SEL_W{1'b0}}, in_word.stack_sel};
	assign idx_in      = sel_ext[SEL_W-1:0];
	assign sel_ok_in   = sel_ext < (SEL_W+2)'(STACKS);
	assign top_in      = sel_ok_in ? stack_top_q[idx_in] : NULL_LINK;
	assign rd_addr     = (in_word.action == ACT_POP) ? top_in[IDX_W-1:0]
	                                                 : free_head_q[IDX_W-1:0];
	assign data_in_ext = {{DATA_WIDTH{1'b0}}, in_word.push_data};

	always_ff @(posedge clk) begin
		if (accept) begin
			data_rd_s1 <= data_mem[rd_addr];
			link_rd_s1 <= link_mem[rd_addr];
		end
		if (data_we) begin
			data_mem[wr_addr] <= data_s1;
		end
		if (link_we) begin
			link_mem[wr_addr] <= wr_link;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= in_word.action;
			sel_ok_s1 <= sel_ok_in;
			idx_s1    <= idx_in;
			data_s1   <= data_in_ext[DATA_WIDTH-1:0];
			top_s1    <= top_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		push_ok  = 1'b0;
		pop_ok   = 1'b0;
		load_out = 1'b0;
		// never-allocated entries chain to the next index
		head_link = (free_head_q >= hwm_q) ? free_head_q + LINK_W'(1) : link_rd_s1;
		pop_ext   = {32'b0, data_rd_s1};
		ones_ext  = {32'b0, {DATA_WIDTH{1'b1}}};
		out_d.pop_data = '0;
		out_d.status   = ST_DONE;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d  = S_IDLE;
				load_out = 1'b1;
				if (action_s1 == ACT_PUSH) begin
					if (!sel_ok_s1 || free_head_q >= NULL_LINK) begin
						out_d.status = ST_FULL;
					end else begin
						push_ok = 1'b1;
					end
				end else begin
					if (!sel_ok_s1 || top_s1 >= NULL_LINK) begin
						out_d.pop_data = ones_ext[31:0];
						out_d.status   = ST_EMPTY;
					end else begin
						pop_ok         = 1'b1;
						out_d.pop_data = pop_ext[31:0];
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
		data_we = push_ok;
		link_we = push_ok || pop_ok;
		wr_addr = push_ok ? free_head_q[IDX_W-1:0] : top_s1[IDX_W-1:0];
		wr_link = push_ok ? top_s1 : free_head_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			hwm_q       <= '0;
			for (int i = 0; i < STACKS; i++) begin
				stack_top_q[i] <= NULL_LINK;
			end
		end else if (push_ok) begin
			free_head_q         <= head_link;
			stack_top_q[idx_s1] <= free_head_q;
			if (free_head_q == hwm_q) begin
				hwm_q <= hwm_q + LINK_W'(1);
			end
		end else if (pop_ok) begin
			free_head_q         <= top_s1;
			stack_top_q[idx_s1] <= link_rd_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_word_q <= out_d;
		end
	end

	a_exec_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_EXEC)
		else $error("no execute cycle after accept");

	a_exec_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC |=> state_q == S_IDLE && out_valid_q)
		else $error("execute did not finish with a result");

	a_out_free_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC |-> !out_valid_q)
		else $error("result register busy during execute");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_head_q <= NULL_LINK && hwm_q <= NULL_LINK)
		else $error("free head or high-water count out of range");

	a_no_double_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(push_ok && pop_ok))
		else $error("push and pop in the same cycle");

endmodule
